>>> design/hmt_pkg.sv
package hmt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W   = 32;
    localparam int PORT_W = 16;
    localparam int BEAT_W = 32;
    localparam int TIME_W = 32;
    localparam int TMO_W  = 16;
    localparam int OCNT_W = 6;

    typedef enum logic [2:0] {
        ST_REFRESH = 3'd0,
        ST_STALE   = 3'd1,
        ST_ADDED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_REMOVED = 3'd4,
        ST_DONE    = 3'd5
    } status_t;

    // request walking down the cell chain
    typedef struct packed {
        logic              sweep;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
        logic [TIME_W-1:0] now;
        logic              found;
        status_t           status;
        logic [BEAT_W-1:0] hit_beat;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } tok_t;

    // insert into one slot, broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
        logic [TIME_W-1:0] now;
    } wr_t;

    // entry removed by a sweep, all zero when idle so cells can be OR-ed
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
    } rem_t;

endpackage

>>> design/hmt_cell.sv
module hmt_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [hmt_pkg::IDX_W-1:0]   cell_idx,
    input  logic                        stall,
    input  logic [hmt_pkg::TMO_W-1:0]   fail_timeout,
    input  hmt_pkg::wr_t                wr,
    input  logic                        tok_in_valid,
    input  hmt_pkg::tok_t               tok_in,
    output logic                        tok_out_valid,
    output hmt_pkg::tok_t               tok_out,
    output hmt_pkg::rem_t               rem
);

    logic                         valid_reg;
    logic [hmt_pkg::ID_W-1:0]     id_reg;
    logic [hmt_pkg::PORT_W-1:0]   port_reg;
    logic [hmt_pkg::BEAT_W-1:0]   beat_reg;
    logic [hmt_pkg::TIME_W-1:0]   seen_reg;

    logic                         tok_valid_reg;
    hmt_pkg::tok_t                tok_reg;
    hmt_pkg::tok_t                tok_next;

    logic                         hit;
    logic                         newer;
    logic                         expired;
    logic [hmt_pkg::TIME_W-1:0]   age;
    logic                         active;
    logic                         do_refresh;
    logic                         do_remove;
    logic                         do_write;

    assign hit     = valid_reg && (id_reg == tok_in.id) && (port_reg == tok_in.port);
    assign newer   = tok_in.beat > beat_reg;
    assign age     = tok_in.now - seen_reg;
    assign expired = age > hmt_pkg::TIME_W'(fail_timeout);
    assign active  = tok_in_valid && !stall;

    assign do_refresh = active && !tok_in.sweep && !tok_in.found && hit && newer;
    assign do_remove  = active && tok_in.sweep && valid_reg && expired;
    assign do_write   = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.sweep)
        begin
            if (!tok_in.found && hit)
            begin
                tok_next.found = 1'b1;
                if (newer)
                begin
                    tok_next.status   = hmt_pkg::ST_REFRESH;
                    tok_next.hit_beat = tok_in.beat;
                end
                else
                begin
                    tok_next.status   = hmt_pkg::ST_STALE;
                    tok_next.hit_beat = beat_reg;
                end
            end
            else if (!valid_reg && !tok_in.free_found)
            begin
                tok_next.free_found = 1'b1;
                tok_next.free_idx   = cell_idx;
            end
        end
    end

    // removal request is raised before stall is known; the top holds the chain if needed
    always_comb
    begin
        rem = '0;
        if (tok_in_valid && tok_in.sweep && valid_reg && expired)
        begin
            rem.valid = 1'b1;
            rem.id    = id_reg;
            rem.port  = port_reg;
            rem.beat  = beat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_write)
                valid_reg <= 1'b1;
            else if (do_remove)
                valid_reg <= 1'b0;
            if (!stall)
                tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            id_reg   <= wr.id;
            port_reg <= wr.port;
            beat_reg <= wr.beat;
            seen_reg <= wr.now;
        end
        else if (do_refresh)
        begin
            beat_reg <= tok_in.beat;
            seen_reg <= tok_in.now;
        end
        if (!stall)
            tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

>>> design/heartbeat_membership_table.sv
// Membership table of TABLE_ENTRIES members, one per cell in a chain. Each word
// is taken in by a request that walks the chain one cell per clock while the
// output is not held off; s_tready stays low until the request has left the
// last cell. An update gives one result word; a sweep gives one word per
// removed member, in slot order, then a done word with tlast set.
// fail_timeout can be written at any idle time.
module heartbeat_membership_table (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_wr_en,
    input  logic [hmt_pkg::TMO_W-1:0]    cfg_wr_data,   // fail_timeout

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [111:0]                 s_tdata,   // node_id, node_port, heartbeat, now
    input  logic                         s_tuser,   // mode

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [87:0]                  m_tdata,   // entry_id, entry_port, entry_heartbeat,
                                                    // member_count, 2 pad bits
    output logic [2:0]                   m_tuser,   // status
    output logic                         m_tlast
);

    logic [hmt_pkg::TMO_W-1:0]   timeout_reg;
    logic                        busy_reg;
    logic [hmt_pkg::CNT_W-1:0]   count_reg;

    logic                        head_valid_reg;
    hmt_pkg::tok_t               head_reg;

    logic                        chain_valid [0:hmt_pkg::TABLE_ENTRIES];
    hmt_pkg::tok_t               chain_tok   [0:hmt_pkg::TABLE_ENTRIES];
    hmt_pkg::rem_t               cell_rem    [0:hmt_pkg::TABLE_ENTRIES-1];

    hmt_pkg::rem_t               rem_any;
    hmt_pkg::wr_t                wr;
    logic                        tail_valid;
    hmt_pkg::tok_t               tail;

    logic                        accept;
    logic                        emit_want;
    logic                        can_load;
    logic                        stall;
    logic                        fire;

    hmt_pkg::status_t            res_status;
    logic [hmt_pkg::ID_W-1:0]    res_id;
    logic [hmt_pkg::PORT_W-1:0]  res_port;
    logic [hmt_pkg::BEAT_W-1:0]  res_beat;
    logic [hmt_pkg::CNT_W-1:0]   res_count;
    logic                        res_last;

    logic                        m_tvalid_reg;
    hmt_pkg::status_t            status_reg;
    logic [hmt_pkg::ID_W-1:0]    id_reg;
    logic [hmt_pkg::PORT_W-1:0]  port_reg;
    logic [hmt_pkg::BEAT_W-1:0]  beat_reg;
    logic [hmt_pkg::CNT_W-1:0]   mcount_reg;
    logic                        last_reg;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    assign chain_valid[0] = head_valid_reg;
    assign chain_tok[0]   = head_reg;

    for (genvar i = 0; i < hmt_pkg::TABLE_ENTRIES; i++)
    begin : g_cell
        hmt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_idx      (hmt_pkg::IDX_W'(i)),
            .stall         (stall),
            .fail_timeout  (timeout_reg),
            .wr            (wr),
            .tok_in_valid  (chain_valid[i]),
            .tok_in        (chain_tok[i]),
            .tok_out_valid (chain_valid[i+1]),
            .tok_out       (chain_tok[i+1]),
            .rem           (cell_rem[i])
        );
    end

    assign tail_valid = chain_valid[hmt_pkg::TABLE_ENTRIES];
    assign tail       = chain_tok[hmt_pkg::TABLE_ENTRIES];

    // only one request is in flight, so at most one cell raises a removal
    always_comb
    begin
        rem_any = '0;
        for (int i = 0; i < hmt_pkg::TABLE_ENTRIES; i++)
            rem_any = rem_any | cell_rem[i];
    end

    assign emit_want = rem_any.valid || tail_valid;
    assign can_load  = !m_tvalid_reg || m_tready;
    assign stall     = emit_want && !can_load;
    assign fire      = emit_want && can_load;

    always_comb
    begin
        res_status = hmt_pkg::ST_DONE;
        res_id     = '0;
        res_port   = '0;
        res_beat   = '0;
        res_count  = count_reg;
        res_last   = 1'b1;
        wr         = '0;
        wr.idx     = tail.free_idx;
        wr.id      = tail.id;
        wr.port    = tail.port;
        wr.beat    = tail.beat;
        wr.now     = tail.now;
        if (rem_any.valid)
        begin
            res_status = hmt_pkg::ST_REMOVED;
            res_id     = rem_any.id;
            res_port   = rem_any.port;
            res_beat   = rem_any.beat;
            res_count  = count_reg - hmt_pkg::CNT_W'(1);
            res_last   = 1'b0;
        end
        else if (!tail.sweep)
        begin
            res_id   = tail.id;
            res_port = tail.port;
            if (tail.found)
            begin
                res_status = tail.status;
                res_beat   = tail.hit_beat;
            end
            else if (tail.free_found)
            begin
                res_status = hmt_pkg::ST_ADDED;
                res_beat   = tail.beat;
                res_count  = count_reg + hmt_pkg::CNT_W'(1);
                wr.en      = tail_valid && !stall;
            end
            else
            begin
                res_status = hmt_pkg::ST_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= hmt_pkg::TMO_W'(5);
            busy_reg       <= 1'b0;
            count_reg      <= '0;
            head_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;

            if (accept)
                busy_reg <= 1'b1;
            else if (tail_valid && !stall)
                busy_reg <= 1'b0;

            if (accept)
                head_valid_reg <= 1'b1;
            else if (!stall)
                head_valid_reg <= 1'b0;

            if (fire)
                count_reg <= res_count;

            if (fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg.sweep      <= s_tuser;
            head_reg.id         <= s_tdata[31:0];
            head_reg.port       <= s_tdata[47:32];
            head_reg.beat       <= s_tdata[79:48];
            head_reg.now        <= s_tdata[111:80];
            head_reg.found      <= 1'b0;
            head_reg.status     <= hmt_pkg::ST_REFRESH;
            head_reg.hit_beat   <= '0;
            head_reg.free_found <= 1'b0;
            head_reg.free_idx   <= '0;
        end
        if (fire)
        begin
            status_reg <= res_status;
            id_reg     <= res_id;
            port_reg   <= res_port;
            beat_reg   <= res_beat;
            mcount_reg <= res_count;
            last_reg   <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, hmt_pkg::OCNT_W'(mcount_reg), beat_reg, port_reg, id_reg};

endmodule

>>> design/hmt_checker.sv
module hmt_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast
);

    // held word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // one word at a time: the block closes its input after taking a word
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // only removals are mid-run words
    a_mid_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == hmt_pkg::ST_REMOVED)
        else $error("non-removal word without tlast");

    a_last_not_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser != hmt_pkg::ST_REMOVED)
        else $error("removal word carries tlast");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[85:80] <= hmt_pkg::OCNT_W'(hmt_pkg::TABLE_ENTRIES))
        else $error("member count beyond table size");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
